### design/gpe_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the gradient palette expander.
// No dependencies; imported by the interfaces, the core and the top level.
package gpe_pkg;

    localparam int MAX_KEYS  = 16;
    localparam int MAX_LEDS  = 1024;
    localparam int KEY_W     = $clog2(MAX_KEYS);       // key slot index
    localparam int CNT_W     = KEY_W + 1;              // holds MAX_KEYS
    localparam int POS_W     = $clog2(MAX_LEDS);       // led position
    localparam int LEN_W     = POS_W + 1;              // holds MAX_LEDS
    localparam int COLOR_W   = 24;
    localparam int CH_W      = 8;
    localparam int NUM_CH    = COLOR_W / CH_W;
    localparam int PROD_W    = POS_W + CNT_W;          // (i+1)*count, phase*length
    localparam int NUM_W     = CH_W + POS_W;           // blend numerator

    // stage map
    localparam int ST_PH0    = 1;                      // phase quotient, one bit a stage
    localparam int PH_BITS   = KEY_W;
    localparam int ST_SEG    = ST_PH0 + PH_BITS;       // segment products
    localparam int ST_SEG0   = ST_SEG + 1;             // offset quotients, one bit a stage
    localparam int SEG_BITS  = LEN_W;
    localparam int ST_LEN    = ST_SEG0 + SEG_BITS;     // segment length and position
    localparam int ST_KEY    = ST_LEN + 1;             // palette read / write
    localparam int ST_MUL    = ST_KEY + 1;             // blend products
    localparam int ST_DIV0   = ST_MUL + 1;             // blend quotients
    localparam int NUM_ST    = ST_DIV0 + CH_W;

    localparam int ADDR_W    = 4;
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_REPEAT = 2'd1;
    localparam logic [1:0] REG_COUNT  = 2'd2;
    localparam logic [1:0] REG_LENGTH = 2'd3;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic             literal;
        logic [1:0]       shamt;
        logic [CNT_W-1:0] cnt;
        logic [LEN_W-1:0] len;
    } t_cfg;

    typedef struct packed {
        logic                             is_wr;
        logic [KEY_W-1:0]                 kidx;
        logic [COLOR_W-1:0]               kcol;
        logic [POS_W-1:0]                 echo;
        logic [POS_W-1:0]                 idx;
        logic [PROD_W-1:0]                rem_p;
        logic [KEY_W-1:0]                 phase;
        logic [PROD_W-1:0]                rem_o;
        logic [LEN_W-1:0]                 q_o;
        logic [PROD_W-1:0]                rem_n;
        logic [LEN_W-1:0]                 q_n;
        logic [POS_W-1:0]                 rem_l;
        logic [LEN_W-1:0]                 len;
        logic [POS_W-1:0]                 pos;
        logic [KEY_W-1:0]                 ka;
        logic [KEY_W-1:0]                 kb;
        logic [POS_W-1:0]                 dv;
        logic [NUM_CH-1:0][NUM_W-1:0]     rem_c;
        logic [NUM_CH-1:0][CH_W-1:0]      quo;
    } t_pipe;

endpackage

### design/gpe_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for lookup/write requests and colors.
// Depends on gpe_pkg.
interface gpe_in_if;
    import gpe_pkg::*;
    logic               valid;
    logic               ready;
    logic               op;
    logic [KEY_W-1:0]   key_index;
    logic [COLOR_W-1:0] key_color;
    logic [POS_W-1:0]   led_position;
    modport source (output valid, op, key_index, key_color, led_position, input ready);
    modport sink   (input valid, op, key_index, key_color, led_position, output ready);
endinterface

interface gpe_out_if;
    import gpe_pkg::*;
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel_color;
    logic [POS_W-1:0]   position_echo;
    modport source (output valid, pixel_color, position_echo, input ready);
    modport sink   (input valid, pixel_color, position_echo, output ready);
endinterface

### design/gpe_core.sv
`timescale 1ns / 1ps
// Pipelined datapath: segment search, palette store and channel blend.
// Depends on gpe_pkg and gpe_if.
module gpe_core
    import gpe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    gpe_in_if.sink      i_in,
    gpe_out_if.source   o_out
);

    t_pipe              r_st [NUM_ST];
    t_pipe              n_st [NUM_ST];
    logic [NUM_ST-1:0]  r_v;
    logic [NUM_ST-1:0]  en;
    logic [COLOR_W-1:0] r_mem [MAX_KEYS];
    logic [COLOR_W-1:0] r_ka;
    logic [COLOR_W-1:0] r_kb;

    // each stage moves when it is empty or its successor moves
    always_comb begin
        en[NUM_ST-1] = !r_v[NUM_ST-1] || r_st[NUM_ST-1].is_wr || o_out.ready;
        for (int s = NUM_ST-2; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    assign i_in.ready = en[0];

    always_comb begin
        int                  k;
        logic [PROD_W-1:0]   dvs;
        logic [PROD_W-1:0]   cvs;
        logic [NUM_W-1:0]    bvs;
        logic [POS_W-1:0]    wa;
        logic [CH_W-1:0]     ca;
        logic [CH_W-1:0]     cb;
        n_st[0]        = '0;
        n_st[0].is_wr  = (i_in.op == OP_WRITE);
        n_st[0].kidx   = i_in.key_index;
        n_st[0].kcol   = i_in.key_color;
        n_st[0].echo   = i_in.led_position;
        n_st[0].idx    = ({1'b0, i_in.led_position} >= i_cfg.len) ?
                         POS_W'(i_cfg.len - LEN_W'(1)) : i_in.led_position;
        n_st[0].rem_p  = PROD_W'((PROD_W'(n_st[0].idx) + PROD_W'(1)) * PROD_W'(i_cfg.cnt))
                         - PROD_W'(1);
        for (int s = 1; s < NUM_ST; s++) begin
            n_st[s] = r_st[s-1];
            k   = 0;
            dvs = '0;
            cvs = '0;
            bvs = '0;
            wa  = '0;
            ca  = '0;
            cb  = '0;
            if (s >= ST_PH0 && s < ST_SEG) begin
                k   = PH_BITS - 1 - (s - ST_PH0);
                dvs = PROD_W'(i_cfg.len) << k;
                if (r_st[s-1].rem_p >= dvs) begin
                    n_st[s].rem_p    = r_st[s-1].rem_p - dvs;
                    n_st[s].phase[k] = 1'b1;
                end
            end else if (s == ST_SEG) begin
                n_st[s].rem_o = PROD_W'(PROD_W'(r_st[s-1].phase) * PROD_W'(i_cfg.len));
                n_st[s].rem_n = PROD_W'((PROD_W'(r_st[s-1].phase) + PROD_W'(1))
                                        * PROD_W'(i_cfg.len));
                n_st[s].rem_l = r_st[s-1].idx >> i_cfg.shamt;
                n_st[s].q_o   = '0;
                n_st[s].q_n   = '0;
            end else if (s >= ST_SEG0 && s < ST_LEN) begin
                k   = SEG_BITS - 1 - (s - ST_SEG0);
                cvs = PROD_W'(i_cfg.cnt) << k;
                if (r_st[s-1].rem_o >= cvs) begin
                    n_st[s].rem_o  = r_st[s-1].rem_o - cvs;
                    n_st[s].q_o[k] = 1'b1;
                end
                if (r_st[s-1].rem_n >= cvs) begin
                    n_st[s].rem_n  = r_st[s-1].rem_n - cvs;
                    n_st[s].q_n[k] = 1'b1;
                end
                if (PROD_W'(r_st[s-1].rem_l) >= cvs) begin
                    n_st[s].rem_l = POS_W'(PROD_W'(r_st[s-1].rem_l) - cvs);
                end
            end else if (s == ST_LEN) begin
                n_st[s].len = r_st[s-1].q_n - r_st[s-1].q_o;
                if (n_st[s].len == '0) begin
                    n_st[s].len = LEN_W'(1);
                end
                n_st[s].pos = ({1'b0, r_st[s-1].idx} >= r_st[s-1].q_o) ?
                              POS_W'({1'b0, r_st[s-1].idx} - r_st[s-1].q_o) : '0;
                if ({1'b0, n_st[s].pos} >= n_st[s].len) begin
                    n_st[s].pos = POS_W'(n_st[s].len - LEN_W'(1));
                end
                n_st[s].ka = i_cfg.literal ? r_st[s-1].rem_l[KEY_W-1:0] : r_st[s-1].phase;
                n_st[s].kb = (CNT_W'(r_st[s-1].phase) + CNT_W'(1) == i_cfg.cnt) ?
                             '0 : KEY_W'(r_st[s-1].phase + KEY_W'(1));
            end else if (s == ST_MUL) begin
                wa = POS_W'(r_st[s-1].len - LEN_W'(1) - LEN_W'(r_st[s-1].pos));
                for (int c = 0; c < NUM_CH; c++) begin
                    ca = r_ka[c*CH_W +: CH_W];
                    cb = r_kb[c*CH_W +: CH_W];
                    n_st[s].quo[c] = '0;
                    if (i_cfg.literal || r_st[s-1].len == LEN_W'(1)) begin
                        n_st[s].rem_c[c] = NUM_W'(ca);
                    end else begin
                        n_st[s].rem_c[c] = NUM_W'(NUM_W'(ca) * NUM_W'(wa))
                                         + NUM_W'(NUM_W'(cb) * NUM_W'(r_st[s-1].pos));
                    end
                end
                n_st[s].dv = (i_cfg.literal || r_st[s-1].len == LEN_W'(1)) ?
                             POS_W'(1) : POS_W'(r_st[s-1].len - LEN_W'(1));
            end else if (s >= ST_DIV0) begin
                k   = CH_W - 1 - (s - ST_DIV0);
                bvs = NUM_W'(r_st[s-1].dv) << k;
                for (int c = 0; c < NUM_CH; c++) begin
                    if (r_st[s-1].rem_c[c] >= bvs) begin
                        n_st[s].rem_c[c]  = r_st[s-1].rem_c[c] - bvs;
                        n_st[s].quo[c][k] = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int s = 1; s < NUM_ST; s++) begin
                if (en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NUM_ST; s++) begin
            if (en[s]) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    // palette store; writes land in stream order at the read stage
    always_ff @(posedge i_clk) begin
        if (en[ST_KEY]) begin
            r_ka <= r_mem[r_st[ST_KEY-1].ka];
            r_kb <= r_mem[r_st[ST_KEY-1].kb];
            if (r_v[ST_KEY-1] && r_st[ST_KEY-1].is_wr) begin
                r_mem[r_st[ST_KEY-1].kidx] <= r_st[ST_KEY-1].kcol;
            end
        end
    end

    assign o_out.valid         = r_v[NUM_ST-1] && !r_st[NUM_ST-1].is_wr;
    assign o_out.pixel_color   = r_st[NUM_ST-1].quo;
    assign o_out.position_echo = r_st[NUM_ST-1].echo;

endmodule

### design/gradient_palette_expander.sv
`timescale 1ns / 1ps
// Gradient palette expander: APB register file plus pipelined color lookup.
// Depends on gpe_pkg, gpe_if and gpe_core.
// From accepted lookup to color valid: bit-per-stage phase quotient, segment products,
// bit-per-stage segment bounds, length and position, palette read, blend products, blend quotients.
// Throughput: one transaction per cycle unless o_out stalls; key writes take a pipeline slot, no result.
// Reset (synchronous, active low) empties the pipeline and loads register defaults;
// palette entries hold no value until written.
module gradient_palette_expander
    import gpe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    gpe_in_if.sink            i_in,
    gpe_out_if.source         o_out
);

    logic        r_mode;
    logic [2:0]  r_level;
    logic [4:0]  r_count;
    logic [10:0] r_length;
    t_cfg        cfg;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_level  <= 3'd1;
            r_count  <= 5'd1;
            r_length <= 11'd16;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_MODE:   r_mode   <= pwdata[0];
                REG_REPEAT: r_level  <= pwdata[2:0];
                REG_COUNT:  r_count  <= pwdata[4:0];
                REG_LENGTH: r_length <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MODE:   prdata = 32'(r_mode);
            REG_REPEAT: prdata = 32'(r_level);
            REG_COUNT:  prdata = 32'(r_count);
            REG_LENGTH: prdata = 32'(r_length);
            default:    prdata = '0;
        endcase
    end

    // out-of-range register values clamp to the nearest legal setting
    always_comb begin
        cfg.literal = r_mode;
        if (r_level == 3'd0) begin
            cfg.shamt = 2'd0;
        end else if (r_level > 3'd4) begin
            cfg.shamt = 2'd3;
        end else begin
            cfg.shamt = 2'(r_level - 3'd1);
        end
        if (r_count == 5'd0) begin
            cfg.cnt = CNT_W'(1);
        end else if (32'(r_count) > MAX_KEYS) begin
            cfg.cnt = CNT_W'(MAX_KEYS);
        end else begin
            cfg.cnt = CNT_W'(r_count);
        end
        if (r_length == 11'd0) begin
            cfg.len = LEN_W'(1);
        end else if (32'(r_length) > MAX_LEDS) begin
            cfg.len = LEN_W'(MAX_LEDS);
        end else begin
            cfg.len = LEN_W'(r_length);
        end
    end

    gpe_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule
